@@ rtl/core/dnfa_pkg.sv @@
// shared types, constants and helper functions of the distinct non-negative filter
// depends on nothing; every other file of the block imports it
`default_nettype none

package dnfa_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int VALUE_W    = 31;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = 47;
  localparam int AVG_W      = 31;
  localparam int TREE_FANIN = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_END_SET = 2'd1,
    CMD_REPORT  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NEGATIVE  = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                       command;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic               kept;
    status_e            status;
    logic [COUNT_W-1:0] total_count;
    logic [AVG_W-1:0]   average;
  } out_rsp_t;

  // node count of one level of the hit reduction tree
  function automatic int tree_nodes(int n, int lvl);
    int k;
    k = n;
    for (int i = 0; i < lvl; i++) begin
      k = (k + TREE_FANIN - 1) / TREE_FANIN;
    end
    return k;
  endfunction

  // register levels needed to reduce n hits to one
  function automatic int tree_levels(int n);
    int k;
    int l;
    k = n;
    l = 0;
    while (k > 1) begin
      k = (k + TREE_FANIN - 1) / TREE_FANIN;
      l++;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dnfa_cell.sv @@
// one table cell: holds a stored value, hands it to the next cell on insert
// and flags a registered match against the probe; uses dnfa_pkg
`default_nettype none

module dnfa_cell
  import dnfa_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int FILL_W = 9
) (
  input  wire logic               clk_i,
  input  wire logic               shift_i,
  input  wire logic [VALUE_W-1:0] prev_i,
  input  wire logic [VALUE_W-1:0] probe_i,
  input  wire logic [FILL_W-1:0]  fill_i,
  output logic      [VALUE_W-1:0] value_o,
  output logic                    hit_o
);

  logic [VALUE_W-1:0] value_q;
  logic               hit_q;
  logic               live;

  // entry is occupied when its position is below the fill count
  assign live = fill_i > FILL_W'(IDX);

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      value_q <= prev_i;
    end
    hit_q <= live && (value_q == probe_i);
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

@@ rtl/core/dnfa_hit_tree.sv @@
// registered or-reduction tree over the per-cell match flags
// each tree level is registered; uses dnfa_pkg
`default_nettype none

module dnfa_hit_tree
  import dnfa_pkg::*;
#(
  parameter int N = 256
) (
  input  wire logic         clk_i,
  input  wire logic [N-1:0] hits_i,
  output logic              any_o
);

  localparam int LEVELS = tree_levels(N);

  logic [N-1:0] lvl [LEVELS+1];

  assign lvl[0] = hits_i;

  for (genvar l = 1; l <= LEVELS; l++) begin : g_level
    localparam int PREV  = tree_nodes(N, l - 1);
    localparam int NODES = tree_nodes(N, l);
    for (genvar j = 0; j < N; j++) begin : g_node
      if (j < NODES) begin : g_or
        localparam int LO = j * TREE_FANIN;
        localparam int GW = (PREV - LO < TREE_FANIN) ? PREV - LO : TREE_FANIN;
        logic node_q;
        always_ff @(posedge clk_i) begin
          node_q <= |lvl[l-1][LO +: GW];
        end
        assign lvl[l][j] = node_q;
      end else begin : g_unused
        assign lvl[l][j] = 1'b0;
      end
    end
  end

  assign any_o = lvl[LEVELS][0];

endmodule

`default_nettype wire

@@ rtl/core/dnfa_divider.sv @@
// restoring divider, one quotient bit per cycle, for the report average
// uses dnfa_pkg for the sum and count widths
`default_nettype none

module dnfa_divider
  import dnfa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SUM_W-1:0]   dividend_i,
  input  wire logic [COUNT_W-1:0] divisor_i,
  output logic                    busy_o,
  output logic      [SUM_W-1:0]   quotient_o
);

  localparam int STEP_W = $clog2(SUM_W);

  logic               busy_q;
  logic [STEP_W-1:0]  step_q;
  logic [COUNT_W-1:0] rem_q;
  logic [COUNT_W-1:0] div_q;
  logic [SUM_W-1:0]   quo_q;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(SUM_W - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/distinct_nonnegative_filter_average.sv @@
// top level of the distinct non-negative sample filter with running average
// uses dnfa_pkg, dnfa_cell, dnfa_hit_tree and dnfa_divider
//
// The block takes one request at a time. A non-negative sample request is
// compared against every stored value of the current set in parallel by a row
// of TABLE_DEPTH cells, the match flags go through a registered or-tree of
// fan-in 16, and the value is then kept, or dropped as duplicate or table full.
// A sample's search waits on the compare register in the cells plus the
// or-tree levels. A negative sample is dropped as negative without a search;
// it, an end-of-set request and the unused command go straight to the done
// state. A report with a nonzero count runs a one-bit-per-cycle restoring
// divider over the 47-bit sum; a report with a zero count skips the divider.
// Results sit in an output register, so a finished result waiting on
// out_ready_i does not stop the next request from being accepted; the block
// stalls only when a second result would have to overwrite the first. No
// clearing pass after reset: the table is qualified by its fill count.
`default_nettype none

module distinct_nonnegative_filter_average
  import dnfa_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_rsp_t      out_rsp_o
);

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int LEVELS = tree_levels(TABLE_DEPTH);
  localparam int WAIT_W = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DIV,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [WAIT_W-1:0]  wait_q;
  logic [FILL_W-1:0]  fill_q;
  logic [SUM_W-1:0]   sum_q;
  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;
  out_rsp_t           out_rsp_q;

  // captured request
  cmd_e               cmd_q;
  logic [SAMPLE_W-1:0] sample_q;

  logic               accept;
  logic               commit;
  logic               insert;
  logic               dup_hit;
  logic               div_start;
  logic               div_busy;
  logic [SUM_W-1:0]   quotient;
  logic [VALUE_W-1:0] probe;
  out_rsp_t           rsp;

  logic [VALUE_W-1:0]     cell_val [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_hit;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  // result may land when the output register is empty or being emptied
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign probe      = sample_q[VALUE_W-1:0];
  assign div_start  = accept && (in_req_i.command == CMD_REPORT) && (count_q != '0);

  // row of cells, new values enter at cell 0 and shift down the row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      dnfa_cell #(
        .IDX    (i),
        .FILL_W (FILL_W)
      ) u_cell (
        .clk_i   (clk_i),
        .shift_i (insert),
        .prev_i  (probe),
        .probe_i (probe),
        .fill_i  (fill_q),
        .value_o (cell_val[i]),
        .hit_o   (cell_hit[i])
      );
    end else begin : g_body
      dnfa_cell #(
        .IDX    (i),
        .FILL_W (FILL_W)
      ) u_cell (
        .clk_i   (clk_i),
        .shift_i (insert),
        .prev_i  (cell_val[i-1]),
        .probe_i (probe),
        .fill_i  (fill_q),
        .value_o (cell_val[i]),
        .hit_o   (cell_hit[i])
      );
    end
  end

  dnfa_hit_tree #(
    .N (TABLE_DEPTH)
  ) u_tree (
    .clk_i  (clk_i),
    .hits_i (cell_hit),
    .any_o  (dup_hit)
  );

  dnfa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // result of the captured request, valid in the done state
  always_comb begin
    rsp        = '0;
    rsp.status = ST_OK;
    insert     = 1'b0;
    case (cmd_q)
      CMD_SAMPLE: begin
        if (sample_q[SAMPLE_W-1]) begin
          rsp.status = ST_NEGATIVE;
        end else if (dup_hit) begin
          rsp.status = ST_DUPLICATE;
        end else if (fill_q == FILL_W'(TABLE_DEPTH)) begin
          rsp.status = ST_FULL;
        end else begin
          rsp.kept = 1'b1;
          insert   = commit;
        end
      end
      CMD_REPORT: begin
        rsp.total_count = count_q;
        if (count_q != '0) begin
          rsp.average = quotient[AVG_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // control state, totals and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_req_i.command == CMD_SAMPLE && !in_req_i.sample_value[SAMPLE_W-1]) begin
              state_q <= S_SEARCH;
              wait_q  <= WAIT_W'(LEVELS);
            end else if (div_start) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          // cell compare plus tree levels
          if (wait_q == '0) begin
            state_q <= S_DONE;
          end else begin
            wait_q <= wait_q - 1'b1;
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            if (insert) begin
              fill_q <= fill_q + 1'b1;
              // count saturates, sum freezes with it
              if (count_q != COUNT_MAX) begin
                sum_q   <= sum_q + SUM_W'(probe);
                count_q <= count_q + 1'b1;
              end
            end
            if (cmd_q == CMD_END_SET) begin
              fill_q <= '0;
            end
            if (cmd_q == CMD_REPORT) begin
              fill_q  <= '0;
              sum_q   <= '0;
              count_q <= '0;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_req_i.command;
      sample_q <= in_req_i.sample_value;
    end
    if (commit) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // fill count never runs past the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(TABLE_DEPTH))
    else $error("table fill count beyond depth");

  // divider only runs while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV)
    else $error("divider busy outside divide state");

  // table does not change while a search is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |=> $stable(fill_q))
    else $error("fill count changed during search");

  // saturated count only holds or clears on report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == COUNT_MAX |=> (count_q == COUNT_MAX || count_q == '0))
    else $error("count left saturation");

endmodule

`default_nettype wire
